// ----- rtl/core/bmf_pkg.sv -----
// Shared constants, types and helper function of the box mean filter.
package bmf_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MemAw     = 13;
  localparam int unsigned MemDepth  = 2 ** MemAw;
  localparam int unsigned RecipBits = 28;

  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [28:0] RECIP_1  = 29'(2 ** RecipBits);
  localparam logic [28:0] RECIP_9  = 29'((2 ** RecipBits + 8) / 9);
  localparam logic [28:0] RECIP_25 = 29'((2 ** RecipBits + 24) / 25);
  localparam logic [28:0] RECIP_49 = 29'((2 ** RecipBits + 48) / 49);

  typedef struct packed {
    logic [2:0]  kernel_size;
    logic [10:0] frame_width;
    logic [11:0] frame_height;
    logic        restart;
  } cfg_t;

  // Reciprocal of the window area, scaled by 2^RecipBits and rounded up.
  function automatic logic [28:0] area_recip(input logic [1:0] half);
    logic [28:0] r;
    unique case (half)
      2'd0:    r = RECIP_1;
      2'd1:    r = RECIP_9;
      2'd2:    r = RECIP_25;
      default: r = RECIP_49;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/bmf_in_if.sv -----
// Input channel: pixel or flush item with a valid/ready handshake.
interface bmf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel_in;
  modport source (output valid, output op, output pixel_in, input ready);
  modport sink (input valid, input op, input pixel_in, output ready);
endinterface

// ----- rtl/core/bmf_out_if.sv -----
// Output channel: filtered pixel with a valid/ready handshake.
interface bmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- rtl/core/box_mean_filter_stream.sv -----
// Streaming K-by-K box mean filter over 8-bit grayscale frames.
// Each item is accepted in the idle state; an item that yields a result then reads
// its S-by-S window from the history memory (S is K rounded up to odd), then drains
// the read, scales the sum by the reciprocal area and loads the output register.
// One item per cycle is taken while no result is being computed or waiting for output.
// Reset clears all positions and sets K=3, width 640, height 480; no memory sweep.
module box_mean_filter_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmf_in_if.sink      in_i,
  bmf_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bmf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  cfg_t cfg;

  bmf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0]        state_q, state_d;
  logic [12:0]       in_row_q, in_row_d;
  logic [9:0]        in_col_q, in_col_d;
  logic [11:0]       out_row_q, out_row_d;
  logic [9:0]        out_col_q, out_col_d;
  logic [MemAw-1:0]  wptr_q, wptr_d;
  logic signed [13:0] rr_q, rr_d, row_end_q, row_end_d;
  logic signed [11:0] cc_q, cc_d, col_start_q, col_start_d, col_end_q, col_end_d;
  logic [MemAw-1:0]  raddr_q, raddr_d;
  logic              rd_ok_q, rd_ok_d;
  logic [13:0]       sum_q, sum_d;
  logic [42:0]       prod_q, prod_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_pix_q, out_pix_d;
  logic              out_last_q, out_last_d;

  logic [10:0] w_eff;
  logic [11:0] h_eff;
  logic [1:0]  half;
  logic [12:0] pw;
  logic        in_acc, out_acc;
  logic        we;
  logic [7:0]  wdata;
  logic [7:0]  rdata;
  logic        win_ok;

  logic [12:0] row0;
  logic [9:0]  col0;
  logic [11:0] orow0;
  logic [9:0]  ocol0;
  logic [10:0] col_inc;
  logic [23:0] t_pos;
  logic [23:0] dly;
  logic        restart;
  logic        emit;

  assign w_eff = (cfg.frame_width == 11'd0) ? 11'd1 :
                 (cfg.frame_width > 11'(MaxWidth)) ? 11'(MaxWidth) : cfg.frame_width;
  assign h_eff = (cfg.frame_height == 12'd0) ? 12'd1 : cfg.frame_height;
  assign half  = cfg.kernel_size[2:1];
  assign pw    = {11'd0, half} * {2'd0, w_eff};

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_out  = out_pix_q;
  assign out_o.frame_last = out_last_q;

  assign win_ok = (rr_q >= 14'sd0) && (rr_q < $signed({2'b00, h_eff})) &&
                  (cc_q >= 12'sd0) && (cc_q < $signed({1'b0, w_eff}));

  // A pixel arriving after all rows are in starts a new frame.
  assign restart = !in_i.op && (in_row_q >= {1'b0, h_eff});
  assign row0    = restart ? 13'd0 : in_row_q;
  assign col0    = restart ? 10'd0 : in_col_q;
  assign orow0   = restart ? 12'd0 : out_row_q;
  assign ocol0   = restart ? 10'd0 : out_col_q;
  assign col_inc = {1'b0, col0} + 11'd1;

  // An item yields a result once it lies at least half a window past the first pixel.
  assign t_pos = ({11'd0, row0} * {13'd0, w_eff}) + {14'd0, col0};
  assign dly   = {11'd0, pw} + {22'd0, half};
  assign emit  = (t_pos >= dly);

  assign we    = in_acc && !(in_i.op && (in_row_q == 13'd0) && (in_col_q == 10'd0));
  assign wdata = in_i.op ? 8'd0 : in_i.pixel_in;

  bmf_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q),
    .wdata_i (wdata),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    wptr_d      = wptr_q;
    rr_d        = rr_q;
    row_end_d   = row_end_q;
    cc_d        = cc_q;
    col_start_d = col_start_q;
    col_end_d   = col_end_q;
    raddr_d     = raddr_q;
    rd_ok_d     = 1'b0;
    sum_d       = sum_q;
    prod_d      = prod_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_acc;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;

    if (state_q == ST_RUN || state_q == ST_DRAIN) begin
      if (rd_ok_q) begin
        sum_d = sum_q + {6'd0, rdata};
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (we) begin
          wptr_d = wptr_q + 1'b1;
          if (col_inc >= w_eff) begin
            in_col_d = 10'd0;
            in_row_d = row0 + 13'd1;
          end else begin
            in_col_d = col_inc[9:0];
            in_row_d = row0;
          end
          out_row_d = orow0;
          out_col_d = ocol0;
          if (emit) begin
            rr_d        = $signed({2'b00, orow0}) - $signed({12'd0, half});
            row_end_d   = $signed({2'b00, orow0}) + $signed({12'd0, half});
            cc_d        = $signed({2'b00, ocol0}) - $signed({10'd0, half});
            col_start_d = $signed({2'b00, ocol0}) - $signed({10'd0, half});
            col_end_d   = $signed({2'b00, ocol0}) + $signed({10'd0, half});
            raddr_d     = wptr_q - {pw[11:0], 1'b0} - {10'd0, half, 1'b0};
            sum_d       = 14'd0;
            last_d      = (orow0 == h_eff - 12'd1) && ({1'b0, ocol0} == w_eff - 11'd1);
            state_d     = ST_RUN;
            if ((orow0 == h_eff - 12'd1) && ({1'b0, ocol0} == w_eff - 11'd1)) begin
              in_row_d  = 13'd0;
              in_col_d  = 10'd0;
              out_row_d = 12'd0;
              out_col_d = 10'd0;
            end else if ({1'b0, ocol0} + 11'd1 >= w_eff) begin
              out_col_d = 10'd0;
              out_row_d = orow0 + 12'd1;
            end else begin
              out_col_d = ocol0 + 10'd1;
            end
          end
        end else if (cfg.restart) begin
          in_row_d  = 13'd0;
          in_col_d  = 10'd0;
          out_row_d = 12'd0;
          out_col_d = 10'd0;
        end
      end
      ST_RUN: begin
        rd_ok_d = win_ok;
        if (cc_q == col_end_q) begin
          cc_d    = col_start_q;
          raddr_d = raddr_q + 13'(w_eff) - {10'd0, half, 1'b0};
          if (rr_q == row_end_q) begin
            state_d = ST_DRAIN;
          end else begin
            rr_d = rr_q + 14'sd1;
          end
        end else begin
          cc_d    = cc_q + 12'sd1;
          raddr_d = raddr_q + 13'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = {29'd0, sum_q} * {14'd0, area_recip(half)};
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pix_d   = prod_q[RecipBits+7:RecipBits];
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_row_q    <= 13'd0;
      in_col_q    <= 10'd0;
      out_row_q   <= 12'd0;
      out_col_q   <= 10'd0;
      wptr_q      <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      wptr_q      <= wptr_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q        <= rr_d;
    row_end_q   <= row_end_d;
    cc_q        <= cc_d;
    col_start_q <= col_start_d;
    col_end_q   <= col_end_d;
    raddr_q     <= raddr_d;
    sum_q       <= sum_d;
    prod_q      <= prod_d;
    last_q      <= last_d;
    out_pix_q   <= out_pix_d;
    out_last_q  <= out_last_d;
  end

  // The history pointer moves only when an item is written.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !we |=> $stable(wptr_q))
    else $error("history pointer moved without a write");

  // A window read is only flagged valid right after a read cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      rd_ok_q |-> $past(state_q == ST_RUN))
    else $error("read flag set outside the window scan");

  // A pending result is never overwritten by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_FIN) && out_valid_q && !out_o.ready |=> (state_q == ST_FIN))
    else $error("output overwritten while stalled");

  // The window sum never exceeds 49 full-scale pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_MUL) |-> (sum_q <= 14'd12495))
    else $error("window sum out of range");
endmodule

// ----- rtl/core/bmf_ram.sv -----
// Pixel history memory: one write port, one read port with registered data.
module bmf_ram
  import bmf_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [MemAw-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [MemAw-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem [MemDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/core/bmf_cfg.sv -----
// APB register file holding kernel size and frame geometry.
module bmf_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bmf_pkg::cfg_t       cfg_o
);
  import bmf_pkg::*;

  logic [2:0]  kernel_q, kernel_d;
  logic [10:0] width_q, width_d;
  logic [11:0] height_q, height_d;
  logic        wr_en;
  logic        hit;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    kernel_d = kernel_q;
    width_d  = width_q;
    height_d = height_q;
    hit      = 1'b0;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_KERNEL: begin
          kernel_d = pwdata[2:0];
          hit      = 1'b1;
        end
        REG_WIDTH: begin
          width_d = pwdata[10:0];
          hit     = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = pwdata[11:0];
          hit      = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KERNEL: prdata = {29'd0, kernel_q};
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {20'd0, height_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= 3'd3;
      width_q  <= 11'd640;
      height_q <= 12'd480;
    end else begin
      kernel_q <= kernel_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.kernel_size  = kernel_q;
  assign cfg_o.frame_width  = width_q;
  assign cfg_o.frame_height = height_q;
  assign cfg_o.restart      = hit;
endmodule
